### design/ttcp_pkg.sv
// Shared types and constants for the trail tile cache plotter.
package ttcp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int CLIP_WIDTH  = 15;
   localparam int TAG_WIDTH   = 12;
   localparam int ROW_WORDS   = 8;
   localparam int OFS_WIDTH   = 3;
   localparam int WORD_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CLIP_WIDTH-1:0] CLIP_TOP_RESET    = 15'd0;
   localparam logic [CLIP_WIDTH-1:0] CLIP_BOTTOM_RESET = 15'd144;

   localparam logic [WORD_WIDTH-1:0] PLANE0_MSB = 16'h0080;
   localparam logic [WORD_WIDTH-1:0] PLANE1_MSB = 16'h8000;
   localparam logic [11:0]           CHAR_PALETTE = 12'h800;  // palette 4 at bit 9

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CLIP_TOP    = 2'd0,
      CSR_CLIP_BOTTOM = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_ALLOC,
      ST_PIX_RD,
      ST_PIX_WR
   } state_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic [1:0]                    colour;
   } req_type;

   typedef struct packed {
      logic [6:0]            tile_index;
      logic [OFS_WIDTH-1:0]  row_in_tile;
      logic [WORD_WIDTH-1:0] row_pattern;
      logic                  tile_cleared;
      logic [CLIP_WIDTH-1:0] place_x;
      logic [CLIP_WIDTH-1:0] place_y;
      logic [11:0]           char_code;
   } rsp_type;

   // Tag entry: tile origin plus a mask of rows written since allocation.
   typedef struct packed {
      logic [TAG_WIDTH-1:0] col;
      logic [TAG_WIDTH-1:0] row;
      logic [ROW_WORDS-1:0] row_mask;
   } tag_type;

endpackage

### design/trail_tile_cache_plotter.sv
// Top level of the trail tile cache plotter: tile ring search, allocation and row update.
//
// The block plots 2-bit pixels into a ring of TILE_SLOTS tiles of 8x8 planar pixels. One
// request transaction carries a point and a colour. Points with negative x, or with y outside
// [clip_top, clip_bottom), are dropped. Any other point walks the tag
// memory from the newest live tile to the oldest, one tag per cycle, and stops early on a hit
// or once x lies left of a tile's left edge. A miss allocates the next ring slot (evicting the
// oldest tile when the ring is full). The updated row word comes out in one response
// transaction. The search cost per accepted point grows with the live tile count, as the tag
// memory read port gives one entry per cycle, and is least when the newest tile hits.
// A new request is taken while the previous response still waits in the output register.
// No clearing pass runs after reset: each tag carries a row mask, and a row not yet written
// since its tile was allocated reads as zero, so the pixel memory never needs clearing.
// CSR writes are taken every cycle and must only occur while the block is idle.
module trail_tile_cache_plotter #(
   parameter int TILE_SLOTS = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ttcp_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ttcp_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ttcp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ttcp_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import ttcp_pkg::*;

   localparam int SW = $clog2(TILE_SLOTS);         // slot index width
   localparam int LW = $clog2(TILE_SLOTS + 1);     // live count width
   localparam int PW = SW + OFS_WIDTH;             // pixel memory address width
   localparam logic [SW-1:0] LAST_SLOT = SW'(TILE_SLOTS - 1);

   // ---------------------------------------------------------------- ring helpers
   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + SW'(1);
   endfunction

   function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
      return (s == '0) ? LAST_SLOT : s - SW'(1);
   endfunction

   // ---------------------------------------------------------------- state
   state_type             state_ff, state_in;
   logic [CLIP_WIDTH-1:0] clip_top_ff, clip_top_in;
   logic [CLIP_WIDTH-1:0] clip_bottom_ff, clip_bottom_in;
   logic [SW-1:0]         oldest_ff, oldest_in;
   logic [SW-1:0]         free_ff, free_in;
   logic [LW-1:0]         live_ff, live_in;
   logic [LW-1:0]         issue_left_ff, issue_left_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // per-point working registers (no reset)
   logic [SW-1:0]         issue_addr_ff, issue_addr_in;
   logic [SW-1:0]         rd_slot_ff, rd_slot_in;
   logic [TAG_WIDTH-1:0]  col_ff, col_in;
   logic [TAG_WIDTH-1:0]  row_ff, row_in;
   logic [OFS_WIDTH-1:0]  xo_ff, xo_in;
   logic [OFS_WIDTH-1:0]  yo_ff, yo_in;
   logic [1:0]            colour_ff, colour_in;
   logic [CLIP_WIDTH-1:0] px_ff, px_in;
   logic [CLIP_WIDTH-1:0] py_ff, py_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic [ROW_WORDS-1:0]  mask_ff, mask_in;
   logic                  cleared_ff, cleared_in;
   logic                  use_old_ff, use_old_in;
   rsp_type               rsp_ff, rsp_in;

   // ---------------------------------------------------------------- memories
   tag_type               tag_mem [TILE_SLOTS];
   tag_type               tag_q;
   logic                  tag_re, tag_we;
   logic [SW-1:0]         tag_raddr, tag_waddr;
   tag_type               tag_wdata;

   logic [WORD_WIDTH-1:0] pix_mem [TILE_SLOTS * ROW_WORDS];
   logic [WORD_WIDTH-1:0] pix_q;
   logic                  pix_re, pix_we;
   logic [PW-1:0]         pix_addr;
   logic [WORD_WIDTH-1:0] pix_wdata;

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      if (tag_re) begin
         tag_q <= tag_mem[tag_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_addr] <= pix_wdata;
      end
      if (pix_re) begin
         pix_q <= pix_mem[pix_addr];
      end
   end

   // ---------------------------------------------------------------- datapath helpers
   logic                  y_below_top, y_past_bottom, reject;
   logic [ROW_WORDS-1:0]  row_bit;
   logic [WORD_WIDTH-1:0] bit0, bit1, old_word, new_word;
   logic [31:0]           slot_wide;

   always_comb begin
      y_below_top   = req_data.point_y < $signed({1'b0, clip_top_ff});
      y_past_bottom = req_data.point_y >= $signed({1'b0, clip_bottom_ff});
      reject        = req_data.point_x[COORD_WIDTH-1] || y_below_top || y_past_bottom;

      row_bit  = ROW_WORDS'(1) << yo_ff;
      bit0     = PLANE0_MSB >> xo_ff;
      bit1     = PLANE1_MSB >> xo_ff;
      old_word = use_old_ff ? pix_q : '0;
      new_word = (old_word & ~(bit0 | bit1))
               | (colour_ff[0] ? bit0 : '0)
               | (colour_ff[1] ? bit1 : '0);
      slot_wide = 32'(slot_ff);
   end

   // ---------------------------------------------------------------- control
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      clip_top_in    = clip_top_ff;
      clip_bottom_in = clip_bottom_ff;
      oldest_in      = oldest_ff;
      free_in        = free_ff;
      live_in        = live_ff;
      issue_left_in  = issue_left_ff;
      issue_addr_in  = issue_addr_ff;
      rd_valid_in    = 1'b0;
      rd_slot_in     = rd_slot_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      xo_in          = xo_ff;
      yo_in          = yo_ff;
      colour_in      = colour_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      slot_in        = slot_ff;
      mask_in        = mask_ff;
      cleared_in     = cleared_ff;
      use_old_in     = use_old_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      tag_re    = 1'b0;
      tag_raddr = issue_addr_ff;
      tag_we    = 1'b0;
      tag_waddr = slot_ff;
      tag_wdata = '{col: col_ff, row: row_ff, row_mask: mask_ff | row_bit};
      pix_re    = 1'b0;
      pix_we    = 1'b0;
      pix_addr  = {slot_ff, yo_ff};
      pix_wdata = new_word;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_CLIP_TOP:    clip_top_in    = csr_data[CLIP_WIDTH-1:0];
            CSR_CLIP_BOTTOM: clip_bottom_in = csr_data[CLIP_WIDTH-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reject) begin
               // x and y are known non-negative here
               col_in        = req_data.point_x[COORD_WIDTH-2:OFS_WIDTH];
               row_in        = req_data.point_y[COORD_WIDTH-2:OFS_WIDTH];
               xo_in         = req_data.point_x[OFS_WIDTH-1:0];
               yo_in         = req_data.point_y[OFS_WIDTH-1:0];
               colour_in     = req_data.colour;
               px_in         = req_data.point_x[CLIP_WIDTH-1:0];
               py_in         = req_data.point_y[CLIP_WIDTH-1:0];
               issue_addr_in = slot_dec(free_ff);
               issue_left_in = live_ff;
               state_in      = (live_ff == '0) ? ST_ALLOC : ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            // read newest-to-oldest, one tag per cycle; compare the previous read
            if (issue_left_ff != '0) begin
               tag_re        = 1'b1;
               rd_valid_in   = 1'b1;
               rd_slot_in    = issue_addr_ff;
               issue_addr_in = slot_dec(issue_addr_ff);
               issue_left_in = issue_left_ff - LW'(1);
            end
            priority if (rd_valid_ff && (col_ff < tag_q.col)) begin
               state_in = ST_ALLOC;
            end else if (rd_valid_ff && (col_ff == tag_q.col) && (row_ff == tag_q.row)) begin
               slot_in  = rd_slot_ff;
               mask_in  = tag_q.row_mask;
               state_in = ST_PIX_RD;
            end else if (!rd_valid_ff && (issue_left_ff == '0)) begin
               state_in = ST_ALLOC;
            end else begin
               state_in = ST_SEARCH;   // keep walking
            end
         end

         ST_ALLOC: begin
            // full ring: oldest == free, so the oldest tile gives up its slot
            if ((live_ff != '0) && (oldest_ff == free_ff)) begin
               oldest_in = slot_inc(oldest_ff);
            end else begin
               live_in = live_ff + LW'(1);
            end
            free_in    = slot_inc(free_ff);
            slot_in    = free_ff;
            tag_we     = 1'b1;
            tag_waddr  = free_ff;
            tag_wdata  = '{col: col_ff, row: row_ff, row_mask: row_bit};
            cleared_in = 1'b1;
            use_old_in = 1'b0;
            state_in   = ST_PIX_WR;
         end

         ST_PIX_RD: begin
            pix_re     = 1'b1;
            tag_we     = 1'b1;
            cleared_in = 1'b0;
            use_old_in = mask_ff[yo_ff];
            state_in   = ST_PIX_WR;
         end

         ST_PIX_WR: begin
            if (!rsp_valid_ff || rsp_ready) begin
               pix_we              = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.tile_index   = slot_wide[6:0];
               rsp_in.row_in_tile  = yo_ff;
               rsp_in.row_pattern  = new_word;
               rsp_in.tile_cleared = cleared_ff;
               rsp_in.place_x      = px_ff;
               rsp_in.place_y      = py_ff;
               rsp_in.char_code    = CHAR_PALETTE | slot_wide[11:0];
               state_in            = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         clip_top_ff    <= CLIP_TOP_RESET;
         clip_bottom_ff <= CLIP_BOTTOM_RESET;
         oldest_ff      <= '0;
         free_ff        <= '0;
         live_ff        <= '0;
         issue_left_ff  <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clip_top_ff    <= clip_top_in;
         clip_bottom_ff <= clip_bottom_in;
         oldest_ff      <= oldest_in;
         free_ff        <= free_in;
         live_ff        <= live_in;
         issue_left_ff  <= issue_left_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_addr_ff <= issue_addr_in;
      rd_slot_ff    <= rd_slot_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      xo_ff         <= xo_in;
      yo_ff         <= yo_in;
      colour_ff     <= colour_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      slot_ff       <= slot_in;
      mask_ff       <= mask_in;
      cleared_ff    <= cleared_in;
      use_old_ff    <= use_old_in;
      rsp_ff        <= rsp_in;
   end

endmodule
